// ===== rtl/rcst_pkg.sv =====
// package for the range chmax segment tree unit
// field widths, mode codes, controller states and command/status structs
package rcst_pkg;

   localparam int LEAVES_DEF     = 1024;
   localparam int VALUE_BITS_DEF = 31;

   localparam int MODE_W  = 2;
   localparam int BOUND_W = 11;
   localparam int RAISE_W = 31;
   localparam int POS_W   = 10;
   localparam int OUT_W   = 31;
   localparam int USED_W  = 11;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [USED_W-1:0] USED_RESET = 11'd1024;

   localparam logic [MODE_W-1:0] MODE_CHMAX = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [ADDR_W-1:0] REG_USED_SIZE = 3'd0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_RD_DONE,
      ST_UP_LEVEL,
      ST_UP_LRD,
      ST_UP_LWR,
      ST_UP_RCHK,
      ST_UP_RRD,
      ST_UP_RWR,
      ST_UP_SHIFT
   } state_type;

   typedef struct packed {
      logic load;
      logic clr;
      logic rd_issue;
      logic rd_acc;
      logic up_issue;
      logic up_write;
      logic sel_right;
      logic shift;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              range_ok;
      logic              pos_ok;
      logic              l_lt_r;
      logic              l_odd;
      logic              r_odd;
      logic              p_is_one;
      logic              clr_last;
   } status_type;

endpackage

// ===== rtl/range_chmax_segment_tree_unit.sv =====
// top level of the range chmax segment tree unit
// depends on rcst_pkg, rcst_ctrl, rcst_dp (which holds rcst_ram)
//
// usage:
//   an item is taken when start is high and busy is low. mode 0 raises every
//   position in [left, right) to at least raise_value, mode 1 reads one
//   position, mode 2 clears all nodes, mode 3 does nothing.
//   a read gives one result on rsp_position_value with rsp_valid high for
//   one cycle; the receiver cannot stall, the result must be taken then.
//   steps per item, with L levels (11 for 1024 leaves):
//     read: one node read per level, leaf to root; out of range read: none
//     update: per level a bottom-up cover of up to two nodes,
//       each cover node costs one read and one write of the node memory
//     clear: 2*LEAVES nodes, one node per cycle
//   the node memory port takes one read and one write per cycle.
//   after reset the unit sweeps all 2*LEAVES nodes of the node memory to zero
//   with busy high; configuration writes are taken at any time.
//   register used_size at byte address 0 sets the leaf count in use.
module range_chmax_segment_tree_unit
   import rcst_pkg::*;
#(
   parameter int LEAVES     = LEAVES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [BOUND_W-1:0] req_range_left,
   input  logic [BOUND_W-1:0] req_range_right,
   input  logic [RAISE_W-1:0] req_raise_value,
   input  logic [POS_W-1:0]   req_read_position,
   output logic               rsp_valid,
   output logic [OUT_W-1:0]   rsp_position_value,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   cmd_type    cmd;
   status_type stat;

   rcst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   rcst_dp #(
      .LEAVES     (LEAVES),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .req_mode           (req_mode),
      .req_range_left     (req_range_left),
      .req_range_right    (req_range_right),
      .req_raise_value    (req_raise_value),
      .req_read_position  (req_read_position),
      .rsp_valid          (rsp_valid),
      .rsp_position_value (rsp_position_value)
   );

   assign pready = 1'b1;

endmodule

// ===== rtl/rcst_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module rcst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rcst_ctrl.sv =====
// controller state machine for the segment tree unit
// depends on rcst_pkg
module rcst_ctrl
   import rcst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type stat,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (stat.mode == MODE_CHMAX) begin
               state_in = stat.range_ok ? ST_UP_LEVEL : ST_IDLE;
            end else if (stat.mode == MODE_READ) begin
               if (stat.pos_ok) begin
                  state_in = ST_RD_ADDR;
               end else begin
                  cmd.emit = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (stat.mode == MODE_CLEAR) begin
               state_in = ST_CLEAR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_ADDR: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            cmd.rd_acc = 1'b1;
            state_in   = stat.p_is_one ? ST_RD_DONE : ST_RD_ADDR;
         end
         ST_RD_DONE: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         ST_UP_LEVEL: begin
            priority if (!stat.l_lt_r) state_in = ST_IDLE;
            else if (stat.l_odd)        state_in = ST_UP_LRD;
            else                        state_in = ST_UP_RCHK;
         end
         ST_UP_LRD: begin
            cmd.up_issue = 1'b1;
            state_in     = ST_UP_LWR;
         end
         ST_UP_LWR: begin
            cmd.up_write = 1'b1;
            state_in     = ST_UP_RCHK;
         end
         ST_UP_RCHK: begin
            state_in = stat.r_odd ? ST_UP_RRD : ST_UP_SHIFT;
         end
         ST_UP_RRD: begin
            cmd.up_issue  = 1'b1;
            cmd.sel_right = 1'b1;
            state_in      = ST_UP_RWR;
         end
         ST_UP_RWR: begin
            cmd.up_write  = 1'b1;
            cmd.sel_right = 1'b1;
            state_in      = ST_UP_SHIFT;
         end
         ST_UP_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = ST_UP_LEVEL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/rcst_dp.sv =====
// datapath: size register, range pointers, node value memory, result register
// depends on rcst_pkg and rcst_ram
module rcst_dp
   import rcst_pkg::*;
#(
   parameter int LEAVES     = LEAVES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         stat,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [BOUND_W-1:0] req_range_left,
   input  logic [BOUND_W-1:0] req_range_right,
   input  logic [RAISE_W-1:0] req_raise_value,
   input  logic [POS_W-1:0]   req_read_position,
   output logic               rsp_valid,
   output logic [OUT_W-1:0]   rsp_position_value
);

   localparam int AW  = $clog2(2 * LEAVES);
   localparam int NW  = AW + 1;
   localparam int NBW = $clog2(LEAVES + 1);
   localparam int VB  = VALUE_BITS;

   logic [USED_W-1:0] used_ff;
   logic [NBW-1:0]    n;
   logic [NW-1:0]     l_ff, r_ff;
   logic [AW-1:0]     p_ff, cnt_ff;
   logic [VB-1:0]     acc_ff, val_ff;
   logic [MODE_W-1:0] mode_ff;
   logic              range_ok_ff, pos_ok_ff;
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_val_ff;

   logic [31:0]   left_sat, right_sat;
   logic [63:0]   raise_ext, acc_ext;
   logic [AW-1:0] sel_addr, rd_addr, wr_addr;
   logic [VB-1:0] rd_data, wr_data, raised;
   logic          wr_en;

   always_comb begin
      if (used_ff == '0) begin
         n = NBW'(1);
      end else if (32'(used_ff) > 32'(LEAVES)) begin
         n = NBW'(LEAVES);
      end else begin
         n = NBW'(used_ff);
      end
      left_sat  = (32'(req_range_left) > 32'(n)) ? 32'(n) : 32'(req_range_left);
      right_sat = (32'(req_range_right) > 32'(n)) ? 32'(n) : 32'(req_range_right);
      raise_ext = 64'(req_raise_value);
      acc_ext   = 64'(acc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= USED_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && paddr == REG_USED_SIZE) begin
            used_ff <= pwdata[USED_W-1:0];
         end
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.clr) begin
            cnt_ff <= cnt_ff + AW'(1);
         end
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff     <= req_mode;
         l_ff        <= NW'(left_sat) + NW'(n);
         r_ff        <= NW'(right_sat) + NW'(n);
         range_ok_ff <= left_sat < right_sat;
         pos_ok_ff   <= 32'(req_read_position) < 32'(n);
         p_ff        <= AW'(32'(req_read_position) + 32'(n));
         val_ff      <= raise_ext[VB-1:0];
         acc_ff      <= '0;
      end
      if (cmd.rd_acc) begin
         if (rd_data > acc_ff) acc_ff <= rd_data;
         p_ff <= p_ff >> 1;
      end
      if (cmd.up_write) begin
         if (cmd.sel_right) r_ff <= r_ff - NW'(1);
         else               l_ff <= l_ff + NW'(1);
      end
      if (cmd.shift) begin
         l_ff <= l_ff >> 1;
         r_ff <= r_ff >> 1;
      end
      if (cmd.emit) begin
         rsp_val_ff <= acc_ext[OUT_W-1:0];
      end
   end

   always_comb begin
      sel_addr = cmd.sel_right ? AW'(r_ff - NW'(1)) : l_ff[AW-1:0];
      rd_addr  = cmd.rd_issue ? p_ff : sel_addr;
      raised   = (rd_data > val_ff) ? rd_data : val_ff;
      wr_en    = cmd.clr | cmd.up_write;
      wr_addr  = cmd.clr ? cnt_ff : sel_addr;
      wr_data  = cmd.clr ? '0 : raised;
   end

   rcst_ram #(
      .WIDTH (VB),
      .DEPTH (2 * LEAVES)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.mode     = mode_ff;
      stat.range_ok = range_ok_ff;
      stat.pos_ok   = pos_ok_ff;
      stat.l_lt_r   = l_ff < r_ff;
      stat.l_odd    = l_ff[0];
      stat.r_odd    = r_ff[0];
      stat.p_is_one = p_ff == AW'(1);
      stat.clr_last = cnt_ff == AW'(2 * LEAVES - 1);
   end

   assign prdata             = (paddr == REG_USED_SIZE) ? DATA_W'(used_ff) : '0;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_value = rsp_val_ff;

endmodule

// ===== sim/tb.sv =====
// testbench for range_chmax_segment_tree_unit: directed table, then random items in phases
// a tree model predicts all but table-typed reads; depends on rcst_pkg and the rtl only
module tb;
   import rcst_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NLEAF = 1024;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [BOUND_W-1:0] left;
      logic [BOUND_W-1:0] right;
      logic [RAISE_W-1:0] raise;
      logic [POS_W-1:0]   pos;
      bit                 typed;
      logic [OUT_W-1:0]   value;
   } item_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [MODE_W-1:0]  req_mode = MODE_CHMAX;
   logic [BOUND_W-1:0] req_range_left = '0;
   logic [BOUND_W-1:0] req_range_right = '0;
   logic [RAISE_W-1:0] req_raise_value = '0;
   logic [POS_W-1:0]   req_read_position = '0;
   logic rsp_valid;
   logic [OUT_W-1:0] rsp_position_value;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   range_chmax_segment_tree_unit dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // tree shadow
   logic [OUT_W-1:0] tree_val [2*NLEAF];
   bit               tree_pend [NLEAF];
   logic [USED_W-1:0] size_reg;
   logic [OUT_W-1:0] value_q [$];
   int errors = 0;
   int n_items = 0, n_reads = 0, n_results = 0;

   function automatic int leaf_count();
      int n;
      n = size_reg;
      if (n == 0) n = 1;
      if (n > NLEAF) n = NLEAF;
      return n;
   endfunction

   function automatic void tree_clear();
      for (int i = 0; i < 2*NLEAF; i++) tree_val[i] = '0;
      for (int i = 0; i < NLEAF; i++) tree_pend[i] = 0;
   endfunction

   function automatic void put_node(int p, logic [OUT_W-1:0] v, int n);
      if (p >= 2*n) return;
      tree_val[p] = v;
      if (p < n) tree_pend[p] = 1;
   endfunction

   function automatic void raise_cover(int p, logic [OUT_W-1:0] x, int n);
      int h, i, q;
      if (p == 0 || p >= 2*n) return;
      h = 0;
      q = p;
      while ((q >> 1) != 0) begin
         q = q >> 1;
         h++;
      end
      for (int s = h; s >= 1; s--) begin
         i = p >> s;
         if (i < n && tree_pend[i]) begin
            if (tree_val[2*i] < tree_val[i]) put_node(2*i, tree_val[i], n);
            if (tree_val[2*i+1] < tree_val[i]) put_node(2*i+1, tree_val[i], n);
         end
         if (i < n) tree_pend[i] = 0;
      end
      if (x > tree_val[p]) put_node(p, x, n);
   endfunction

   function automatic void range_raise(int l, int r, logic [OUT_W-1:0] x, int n);
      if (l > n) l = n;
      if (r > n) r = n;
      if (l >= r) return;
      l += n;
      r += n;
      while (l < r) begin
         if (l & 1) begin
            raise_cover(l, x, n);
            l++;
         end
         if (r & 1) begin
            r--;
            raise_cover(r, x, n);
         end
         l = l >> 1;
         r = r >> 1;
      end
   endfunction

   function automatic logic [OUT_W-1:0] point_value(int pos, int n);
      logic [OUT_W-1:0] m;
      m = '0;
      if (pos >= n) return m;
      for (int p = pos + n; p >= 1; p = p >> 1)
         if (tree_val[p] > m) m = tree_val[p];
      return m;
   endfunction

   task automatic issue(input item_t it);
      int n;
      logic [OUT_W-1:0] v;
      @(negedge clock);
      start <= 1;
      req_mode <= it.mode;
      req_range_left <= it.left;
      req_range_right <= it.right;
      req_raise_value <= it.raise;
      req_read_position <= it.pos;
      do @(posedge clock); while (busy);
      n = leaf_count();
      n_items++;
      case (it.mode)
         MODE_CHMAX: range_raise(it.left, it.right, it.raise, n);
         MODE_READ: begin
            v = point_value(it.pos, n);
            value_q.push_back(it.typed ? it.value : v);
            n_reads++;
         end
         MODE_CLEAR: tree_clear();
         default: ;
      endcase
   endtask

   task automatic idle_cycle();
      @(negedge clock);
      start <= 0;
   endtask

   task automatic wait_quiet();
      idle_cycle();
      while (value_q.size() != 0) @(negedge clock);
      do @(posedge clock); while (busy);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size(input logic [USED_W-1:0] sz);
      wait_quiet();
      psel <= 1;
      pwrite <= 1;
      paddr <= REG_USED_SIZE;
      pwdata <= {$urandom} & ~32'h7ff | sz;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 0;
      size_reg = sz;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      if (prdata[USED_W-1:0] !== sz) begin
         $display("%0t: size readback expected %0d actual %0d", $time, sz, prdata);
         errors++;
      end
      @(negedge clock);
      psel <= 0;
      penable <= 0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         n_results++;
         if (value_q.size() == 0) begin
            $display("%0t: unexpected result, actual %0h", $time, rsp_position_value);
            errors++;
         end else begin
            if (rsp_position_value !== value_q[0]) begin
               $display("%0t: position_value expected %0h actual %0h", $time, value_q[0],
                        rsp_position_value);
               errors++;
            end
            void'(value_q.pop_front());
         end
      end
   end

   item_t table_rows [] = '{
      '{MODE_READ,  0, 0, 0, 0, 1, 31'h0},
      '{MODE_READ,  0, 0, 0, 1023, 1, 31'h0},
      '{MODE_CHMAX, 0, 1024, 31'h7fffffff, 0, 0, 0},
      '{MODE_READ,  0, 0, 0, 0, 1, 31'h7fffffff},
      '{MODE_READ,  0, 0, 0, 1023, 1, 31'h7fffffff},
      '{2'd3,       5, 9, 31'h1, 7, 0, 0},
      '{MODE_CLEAR, 0, 0, 0, 0, 0, 0},
      '{MODE_READ,  0, 0, 0, 512, 1, 31'h0},
      '{MODE_CHMAX, 9, 9, 31'h55, 0, 0, 0},
      '{MODE_CHMAX, 20, 3, 31'h66, 0, 0, 0},
      '{MODE_CHMAX, 2047, 2047, 31'h77, 0, 0, 0},
      '{MODE_READ,  0, 0, 0, 9, 1, 31'h0},
      '{MODE_CHMAX, 0, 2047, 31'h5, 0, 0, 0},
      '{MODE_READ,  0, 0, 0, 1000, 1, 31'h5},
      '{MODE_CHMAX, 3, 4, 31'h1, 0, 0, 0},
      '{MODE_READ,  0, 0, 0, 3, 1, 31'h5},
      '{MODE_CHMAX, 3, 700, 31'h2aaaaaaa, 0, 0, 0},
      '{MODE_CHMAX, 100, 1023, 31'h55555555, 0, 0, 0},
      '{MODE_READ,  0, 0, 0, 2, 0, 0},
      '{MODE_READ,  0, 0, 0, 300, 0, 0},
      '{MODE_READ,  0, 0, 0, 1022, 0, 0},
      '{MODE_READ,  0, 0, 0, 1023, 0, 0},
      '{MODE_CHMAX, 1023, 1024, 31'h7ffffffe, 0, 0, 0},
      '{MODE_READ,  0, 0, 0, 1023, 0, 0}
   };

   logic [USED_W-1:0] phase_size [8] = '{11'd1024, 11'd1, 11'd0, 11'd2047,
                                         11'd37, 11'd600, 11'd5, 11'd130};
   int idle_pct [4] = '{0, 64, 0, 38};

   initial begin
      item_t it;
      int n, k, pct;
      tree_clear();
      size_reg = USED_RESET;
      repeat (6) @(negedge clock);
      reset <= 0;
      foreach (table_rows[i]) issue(table_rows[i]);
      for (int ph = 0; ph < 8; ph++) begin
         write_size(phase_size[ph]);
         n = leaf_count();
         pct = idle_pct[ph % 4];
         for (int j = 0; j < 194; j++) begin
            while ($urandom_range(99) < pct) idle_cycle();
            k = $urandom_range(99);
            it.typed = 0;
            it.value = '0;
            it.raise = $urandom;
            it.pos = (k % 5 == 0) ? $urandom : $urandom_range(n - 1);
            if (k < 90) begin
               it.left = $urandom_range(n);
               it.right = $urandom_range(n);
               if (k % 10 == 0) it.left = $urandom;
               if (k % 10 == 1) it.right = $urandom;
               if (k % 4 != 0 && it.left > it.right) begin
                  it.right = it.left;
                  it.left = $urandom_range(n);
                  if (it.left > it.right) it.left = 0;
               end
            end else begin
               it.left = $urandom;
               it.right = $urandom;
            end
            if (k < 48) it.mode = MODE_CHMAX;
            else if (k < 96) it.mode = MODE_READ;
            else if (k < 98) it.mode = MODE_CLEAR;
            else it.mode = 2'd3;
            issue(it);
         end
         // hold off until every pending read has come back
         wait_quiet();
      end
      wait_quiet();
      repeat (40) @(negedge clock);
      $display("covered %0d items over 8 leaf sizes, %0d reads, %0d results seen",
               n_items, n_reads, n_results);
      if (errors == 0 && value_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/rcst_pkg.sv
rtl/rcst_ram.sv
rtl/rcst_ctrl.sv
rtl/rcst_dp.sv
rtl/range_chmax_segment_tree_unit.sv
sim/tb.sv
